@@ hdl/tril_pkg.sv @@
// Package for the trilateration block: field widths, payload types and register indexes.
package tril_pkg;

   localparam int RANGE_BITS = 16;
   localparam int COORD_BITS = 16;
   localparam int TAG_W      = 8;
   localparam int POS_W      = 32;
   localparam int CSR_INDEX_W = 3;

   // Widths of the intermediate quantities of the linear system.
   localparam int DIFF_W = COORD_BITS + 1;
   localparam int SQ_W   = 2 * RANGE_BITS;
   localparam int K_W    = 2 * COORD_BITS;
   localparam int E_W    = ((SQ_W > K_W) ? SQ_W : K_W) + 2;
   localparam int PD_W   = 2 * DIFF_W;
   localparam int DET_W  = PD_W + 1;
   localparam int PE_W   = E_W + DIFF_W;
   localparam int NUM_W  = PE_W + 1;
   localparam int DEN_W  = DET_W + 1;

   localparam logic [CSR_INDEX_W-1:0] REG_ANCHOR1_X = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] REG_ANCHOR1_Y = CSR_INDEX_W'(1);
   localparam logic [CSR_INDEX_W-1:0] REG_ANCHOR2_X = CSR_INDEX_W'(2);
   localparam logic [CSR_INDEX_W-1:0] REG_ANCHOR2_Y = CSR_INDEX_W'(3);
   localparam logic [CSR_INDEX_W-1:0] REG_ANCHOR3_X = CSR_INDEX_W'(4);
   localparam logic [CSR_INDEX_W-1:0] REG_ANCHOR3_Y = CSR_INDEX_W'(5);

   typedef struct packed {
      logic [TAG_W-1:0]      tag_id;
      logic [RANGE_BITS-1:0] range_1;
      logic [RANGE_BITS-1:0] range_2;
      logic [RANGE_BITS-1:0] range_3;
   } req_type;

   typedef struct packed {
      logic [TAG_W-1:0]        tag_out;
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic                    solved;
   } rsp_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] x1;
      logic signed [COORD_BITS-1:0] y1;
      logic signed [COORD_BITS-1:0] x2;
      logic signed [COORD_BITS-1:0] y2;
      logic signed [COORD_BITS-1:0] x3;
      logic signed [COORD_BITS-1:0] y3;
   } anchor_type;

   // One slot of the divider chain: both quotients share the denominator.
   typedef struct packed {
      logic             valid;
      logic [TAG_W-1:0] tag;
      logic             ok;
      logic             neg_x;
      logic             neg_y;
      logic [DEN_W-1:0] den;
      logic [DEN_W-1:0] rem_x;
      logic [NUM_W-1:0] nq_x;
      logic [DEN_W-1:0] rem_y;
      logic [NUM_W-1:0] nq_y;
   } div_type;

endpackage

@@ hdl/tril_front.sv @@
// Four-stage front end: squares, equation terms, Cramer products and divider setup.
module tril_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               req_valid,
   input  tril_pkg::req_type    req_data,
   input  tril_pkg::anchor_type anchors,
   output tril_pkg::div_type    div_out
);
   import tril_pkg::*;

   // Stage 1 registers.
   logic                     s1_valid_ff;
   logic [TAG_W-1:0]         s1_tag_ff;
   logic [SQ_W-1:0]          r1sq_ff, r2sq_ff, r3sq_ff;
   logic [SQ_W-1:0]          r1sq_in, r2sq_in, r3sq_in;
   logic [K_W-1:0]           k1_ff, k2_ff, k3_ff, k1_in, k2_in, k3_in;
   logic signed [DIFF_W-1:0] a_ff, b_ff, c_ff, d_ff, a_in, b_in, c_in, d_in;
   // Stage 2 registers.
   logic                     s2_valid_ff;
   logic [TAG_W-1:0]         s2_tag_ff;
   logic signed [E_W-1:0]    e_ff, f_ff, e_in, f_in;
   logic signed [E_W-1:0]    r1_e, r2_e, r3_e, k1_e, k2_e, k3_e;
   logic signed [PD_W-1:0]   ad_ff, bc_ff, ad_in, bc_in;
   logic signed [DIFF_W-1:0] a2_ff, b2_ff, c2_ff, d2_ff;
   // Stage 3 registers.
   logic                     s3_valid_ff;
   logic [TAG_W-1:0]         s3_tag_ff;
   logic signed [DET_W-1:0]  det_ff, det_in;
   logic signed [PE_W-1:0]   ed_ff, bf_ff, af_ff, ce_ff, ed_in, bf_in, af_in, ce_in;
   // Stage 4 setup.
   logic signed [NUM_W-1:0]  numx, numy;
   logic signed [DET_W-1:0]  det_mag;
   div_type                  div_ff, div_in;

   assign r1sq_in = req_data.range_1 * req_data.range_1;
   assign r2sq_in = req_data.range_2 * req_data.range_2;
   assign r3sq_in = req_data.range_3 * req_data.range_3;
   assign k1_in   = K_W'(anchors.x1 * anchors.x1 + anchors.y1 * anchors.y1);
   assign k2_in   = K_W'(anchors.x2 * anchors.x2 + anchors.y2 * anchors.y2);
   assign k3_in   = K_W'(anchors.x3 * anchors.x3 + anchors.y3 * anchors.y3);
   assign a_in    = DIFF_W'(anchors.x2) - DIFF_W'(anchors.x1);
   assign b_in    = DIFF_W'(anchors.y2) - DIFF_W'(anchors.y1);
   assign c_in    = DIFF_W'(anchors.x3) - DIFF_W'(anchors.x1);
   assign d_in    = DIFF_W'(anchors.y3) - DIFF_W'(anchors.y1);

   assign r1_e  = E_W'(r1sq_ff);
   assign r2_e  = E_W'(r2sq_ff);
   assign r3_e  = E_W'(r3sq_ff);
   assign k1_e  = E_W'(k1_ff);
   assign k2_e  = E_W'(k2_ff);
   assign k3_e  = E_W'(k3_ff);
   assign e_in  = r1_e - r2_e + k2_e - k1_e;
   assign f_in  = r1_e - r3_e + k3_e - k1_e;
   assign ad_in = a_ff * d_ff;
   assign bc_in = b_ff * c_ff;

   assign det_in = DET_W'(ad_ff) - DET_W'(bc_ff);
   assign ed_in  = e_ff * d2_ff;
   assign bf_in  = f_ff * b2_ff;
   assign af_in  = f_ff * a2_ff;
   assign ce_in  = e_ff * c2_ff;

   always_comb begin
      numx    = NUM_W'(ed_ff) - NUM_W'(bf_ff);
      numy    = NUM_W'(af_ff) - NUM_W'(ce_ff);
      det_mag = det_ff[DET_W-1] ? -det_ff : det_ff;
      div_in.valid = s3_valid_ff;
      div_in.tag   = s3_tag_ff;
      div_in.ok    = (det_ff != '0);
      div_in.neg_x = numx[NUM_W-1] ^ det_ff[DET_W-1];
      div_in.neg_y = numy[NUM_W-1] ^ det_ff[DET_W-1];
      div_in.den   = {det_mag, 1'b0};
      div_in.rem_x = '0;
      div_in.nq_x  = numx[NUM_W-1] ? NUM_W'(-numx) : NUM_W'(numx);
      div_in.rem_y = '0;
      div_in.nq_y  = numy[NUM_W-1] ? NUM_W'(-numy) : NUM_W'(numy);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         div_ff.valid <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         div_ff      <= div_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_tag_ff <= req_data.tag_id;
         r1sq_ff   <= r1sq_in;
         r2sq_ff   <= r2sq_in;
         r3sq_ff   <= r3sq_in;
         k1_ff     <= k1_in;
         k2_ff     <= k2_in;
         k3_ff     <= k3_in;
         a_ff      <= a_in;
         b_ff      <= b_in;
         c_ff      <= c_in;
         d_ff      <= d_in;
         s2_tag_ff <= s1_tag_ff;
         e_ff      <= e_in;
         f_ff      <= f_in;
         ad_ff     <= ad_in;
         bc_ff     <= bc_in;
         a2_ff     <= a_ff;
         b2_ff     <= b_ff;
         c2_ff     <= c_ff;
         d2_ff     <= d_ff;
         s3_tag_ff <= s2_tag_ff;
         det_ff    <= det_in;
         ed_ff     <= ed_in;
         bf_ff     <= bf_in;
         af_ff     <= af_in;
         ce_ff     <= ce_in;
      end
   end

   assign div_out = div_ff;

endmodule

@@ hdl/tril_cell.sv @@
// One cell of the divider chain: a restoring step for each of the two quotients.
module tril_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  tril_pkg::div_type cell_in,
   output tril_pkg::div_type cell_out
);
   import tril_pkg::*;

   logic [DEN_W:0] trial_x, trial_y;
   logic           bit_x, bit_y;
   div_type        cell_ff, cell_in_next;

   always_comb begin
      cell_in_next = cell_in;
      trial_x = {cell_in.rem_x, cell_in.nq_x[NUM_W-1]};
      trial_y = {cell_in.rem_y, cell_in.nq_y[NUM_W-1]};
      bit_x   = (trial_x >= {1'b0, cell_in.den});
      bit_y   = (trial_y >= {1'b0, cell_in.den});
      cell_in_next.rem_x = bit_x ? DEN_W'(trial_x - {1'b0, cell_in.den}) : DEN_W'(trial_x);
      cell_in_next.rem_y = bit_y ? DEN_W'(trial_y - {1'b0, cell_in.den}) : DEN_W'(trial_y);
      cell_in_next.nq_x  = {cell_in.nq_x[NUM_W-2:0], bit_x};
      cell_in_next.nq_y  = {cell_in.nq_y[NUM_W-2:0], bit_y};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else if (en) begin
         cell_ff <= cell_in_next;
      end
   end

   assign cell_out = cell_ff;

endmodule

@@ hdl/trilateration_2d_three_anchor.sv @@
// Top level of the two-dimensional, three-anchor trilateration engine.
// Each request transfer carries a tag and three ranges in millimetres; each yields exactly one
// response transfer with the tag, the x and y position in millimetres and a solved flag. The
// anchor positions are six signed registers written through the csr_ port (index 0 to 5 for
// anchor1_x, anchor1_y, anchor2_x, anchor2_y, anchor3_x, anchor3_y); other indexes are ignored,
// and the registers may only be changed while no request is in flight. The position is the exact
// Cramer's-rule solution of the two linear equations formed by subtracting the circle equations,
// truncated toward zero and saturated to 32 bits. When the anchors are collinear the determinant
// is zero, solved is low and both positions read zero. The block accepts one request every clock
// cycle while req_ready is high. The request is captured at its transfer edge by the first of
// four front-end stages (squares, equation terms, Cramer products, divider setup), then passes
// a chain of 52 divider cells that each settle one quotient bit of both coordinates, and finally
// the response register. A skid register behind the response output takes one more result
// while a response waits; after that req_ready stays low until the waiting response has been
// taken.
module trilateration_2d_three_anchor (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  tril_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output tril_pkg::rsp_type                rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [tril_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [tril_pkg::COORD_BITS-1:0]  csr_data
);
   import tril_pkg::*;

   localparam logic [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};

   // Saturate a quotient magnitude to the signed 32-bit range and apply the sign.
   function automatic logic [POS_W-1:0] sat_pos(input logic [NUM_W-1:0] q, input logic neg);
      logic [NUM_W-1:0] lim;
      logic [NUM_W-1:0] mag;
      lim = NUM_W'(POS_MAX) + NUM_W'(neg);
      mag = (q > lim) ? lim : q;
      mag = neg ? -mag : mag;
      return mag[POS_W-1:0];
   endfunction

   anchor_type anchors_ff;
   logic       en;
   div_type    chain [0:NUM_W];
   rsp_type    result;
   rsp_type    out_ff, skid_ff;
   logic       out_valid_ff, skid_full_ff;
   logic       last_valid;

   // The anchor registers accept a write in every cycle.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         anchors_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            REG_ANCHOR1_X: anchors_ff.x1 <= csr_data;
            REG_ANCHOR1_Y: anchors_ff.y1 <= csr_data;
            REG_ANCHOR2_X: anchors_ff.x2 <= csr_data;
            REG_ANCHOR2_Y: anchors_ff.y2 <= csr_data;
            REG_ANCHOR3_X: anchors_ff.x3 <= csr_data;
            REG_ANCHOR3_Y: anchors_ff.y3 <= csr_data;
            default: ;
         endcase
      end
   end

   // The whole pipeline advances together unless the skid register is occupied.
   assign en        = !skid_full_ff;
   assign req_ready = en;

   tril_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .req_valid (req_valid),
      .req_data  (req_data),
      .anchors   (anchors_ff),
      .div_out   (chain[0])
   );

   // Each cell produces one quotient bit, most significant first.
   for (genvar i = 0; i < NUM_W; i++) begin : g_cell
      tril_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .cell_in  (chain[i]),
         .cell_out (chain[i+1])
      );
   end

   // After the last cell the numerator slots hold the full quotient magnitudes.
   always_comb begin
      result.tag_out = chain[NUM_W].tag;
      result.solved  = chain[NUM_W].ok;
      result.pos_x   = chain[NUM_W].ok ? sat_pos(chain[NUM_W].nq_x, chain[NUM_W].neg_x) : '0;
      result.pos_y   = chain[NUM_W].ok ? sat_pos(chain[NUM_W].nq_y, chain[NUM_W].neg_y) : '0;
   end

   assign last_valid = chain[NUM_W].valid && en;

   // A result leaving the chain goes to the output register when it is free, otherwise to
   // the skid register, which then holds the pipeline until the output drains.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         skid_full_ff <= 1'b0;
      end else if (out_valid_ff && !rsp_ready) begin
         if (last_valid) begin
            skid_full_ff <= 1'b1;
         end
      end else if (skid_full_ff) begin
         out_valid_ff <= 1'b1;
         skid_full_ff <= 1'b0;
      end else begin
         out_valid_ff <= last_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_valid_ff && !rsp_ready) begin
         if (last_valid) begin
            skid_ff <= result;
         end
      end else if (skid_full_ff) begin
         out_ff <= skid_ff;
      end else begin
         out_ff <= result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

@@ hdl/tril_checker.sv @@
// Port-level checker for the trilateration block, bound to the top level.
module tril_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input tril_pkg::req_type                req_data,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input tril_pkg::rsp_type                rsp_data,
   input logic                             csr_valid,
   input logic                             csr_ready,
   input logic [tril_pkg::CSR_INDEX_W-1:0] csr_index,
   input logic [tril_pkg::COORD_BITS-1:0]  csr_data
);
   import tril_pkg::*;

   // A stalled response stays valid.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // A stalled response keeps its payload.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data))
      else $error("response payload changed while stalled");

   // An unsolved position reads as zero.
   a_unsolved_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.solved |-> rsp_data.pos_x == '0 && rsp_data.pos_y == '0)
      else $error("unsolved response with nonzero position");

   // Nothing leaves the block in the first cycle after reset is released.
   a_reset_quiet: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind trilateration_2d_three_anchor tril_checker u_tril_checker (.*);

@@ test/trilateration_2d_three_anchor_test.sv @@
// Self-checking testbench for the three-anchor trilateration engine.
module trilateration_2d_three_anchor_test;
   import tril_pkg::*;

   // Clock and reset. The reset is synchronous and is released by the initial block before the first test.
   logic clock = 1'b0;
   logic reset = 1'b1;

   always #2 clock = ~clock;

   // Request, response and register ports. Every input starts at a known value.
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_type                req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [COORD_BITS-1:0]  csr_data  = '0;

   trilateration_2d_three_anchor DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   // Our own copy of the anchor registers. It is updated on every transfer to indexes 0 to 5, so
   // it always matches what the block holds while requests are in flight.
   logic signed [COORD_BITS-1:0] anchor_pos [6];

   // Positions that are still to come out of the block, oldest first.
   rsp_type pending_positions [$];

   int idle_pct  = 0;   // chance in a hundred that the sender idles in a cycle
   int stall_pct = 0;   // chance in a hundred that the receiver stalls in a cycle
   int errors    = 0;
   int sent      = 0;
   int checked   = 0;
   int unsolved  = 0;

   // Solve the two linear equations by Cramer's rule with the current anchors. Every
   // intermediate value fits in 64 bits: the numerators stay below 2^53.
   function automatic rsp_type solve_position(input req_type item);
      rsp_type pos;
      longint x1, y1, x2, y2, x3, y3, r1, r2, r3;
      longint k1, a, b, c, d, e, f, det, num_x, num_y, qx, qy;
      x1 = longint'(anchor_pos[0]);
      y1 = longint'(anchor_pos[1]);
      x2 = longint'(anchor_pos[2]);
      y2 = longint'(anchor_pos[3]);
      x3 = longint'(anchor_pos[4]);
      y3 = longint'(anchor_pos[5]);
      r1 = longint'(item.range_1);
      r2 = longint'(item.range_2);
      r3 = longint'(item.range_3);
      k1 = x1 * x1 + y1 * y1;
      a = x2 - x1;
      b = y2 - y1;
      c = x3 - x1;
      d = y3 - y1;
      e = r1 * r1 - r2 * r2 + (x2 * x2 + y2 * y2) - k1;
      f = r1 * r1 - r3 * r3 + (x3 * x3 + y3 * y3) - k1;
      det = a * d - b * c;
      pos = '0;
      pos.tag_out = item.tag_id;
      if (det != 0) begin
         num_x = e * d - b * f;
         num_y = a * f - c * e;
         // Integer division truncates toward zero, as the block does.
         qx = num_x / (2 * det);
         qy = num_y / (2 * det);
         if (qx > 64'sd2147483647) qx = 64'sd2147483647;
         if (qx < -64'sd2147483648) qx = -64'sd2147483648;
         if (qy > 64'sd2147483647) qy = 64'sd2147483647;
         if (qy < -64'sd2147483648) qy = -64'sd2147483648;
         pos.pos_x  = qx[POS_W-1:0];
         pos.pos_y  = qy[POS_W-1:0];
         pos.solved = 1'b1;
      end
      return pos;
   endfunction

   // The receiver stalls at random according to stall_pct.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // Compare every response transfer, field by field, with the oldest pending position.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_positions.size() == 0) begin
            errors++;
            $display("%0t: response with nothing pending: %p", $time, rsp_data);
         end else begin
            want = pending_positions.pop_front();
            checked++;
            if (!want.solved) unsolved++;
            if (rsp_data.tag_out !== want.tag_out) begin
               errors++;
               $display("%0t: tag_out expected %0d actual %0d",
                        $time, want.tag_out, rsp_data.tag_out);
            end
            if (rsp_data.pos_x !== want.pos_x) begin
               errors++;
               $display("%0t: pos_x expected %0d actual %0d (tag %0d)",
                        $time, want.pos_x, rsp_data.pos_x, want.tag_out);
            end
            if (rsp_data.pos_y !== want.pos_y) begin
               errors++;
               $display("%0t: pos_y expected %0d actual %0d (tag %0d)",
                        $time, want.pos_y, rsp_data.pos_y, want.tag_out);
            end
            if (rsp_data.solved !== want.solved) begin
               errors++;
               $display("%0t: solved expected %0d actual %0d (tag %0d)",
                        $time, want.solved, rsp_data.solved, want.tag_out);
            end
         end
      end
   end

   // Send one request. The sender may idle first; once valid is raised it stays high,
   // with the payload held, until the transfer happens. Valid is left high afterwards
   // so that back-to-back requests never lower and raise it within one time step.
   task automatic send_ranges(input req_type item);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      pending_positions.push_back(solve_position(item));
      sent++;
   endtask

   // Stop sending, wait for every pending position and let the pipeline empty out.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_positions.size() != 0) @(posedge clock);
      repeat (70) @(posedge clock);
   endtask

   // Write one anchor register. The caller lowers csr_valid after its last write.
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index, input int value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value[COORD_BITS-1:0];
      do @(posedge clock); while (!csr_ready);
      if (index <= REG_ANCHOR3_Y) anchor_pos[index] = value[COORD_BITS-1:0];
   endtask

   task automatic set_anchors(input int ax1, ay1, ax2, ay2, ax3, ay3);
      write_reg(REG_ANCHOR1_X, ax1);
      write_reg(REG_ANCHOR1_Y, ay1);
      write_reg(REG_ANCHOR2_X, ax2);
      write_reg(REG_ANCHOR2_Y, ay2);
      write_reg(REG_ANCHOR3_X, ax3);
      write_reg(REG_ANCHOR3_Y, ay3);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic req_type make_item(input int tag, r1, r2, r3);
      req_type item;
      item.tag_id  = tag[TAG_W-1:0];
      item.range_1 = r1[RANGE_BITS-1:0];
      item.range_2 = r2[RANGE_BITS-1:0];
      item.range_3 = r3[RANGE_BITS-1:0];
      return item;
   endfunction

   // Ranges from a random tag point to the anchors, with a little measurement noise.
   function automatic req_type ranged_item(input int px, py);
      int r [3];
      real dx, dy;
      for (int i = 0; i < 3; i++) begin
         dx = real'(px) - real'(anchor_pos[2*i]);
         dy = real'(py) - real'(anchor_pos[2*i+1]);
         r[i] = $rtoi($sqrt(dx * dx + dy * dy)) + $urandom_range(40) - 20;
         if (r[i] < 0) r[i] = 0;
         if (r[i] > 65535) r[i] = 65535;
      end
      return make_item($urandom_range(255), r[0], r[1], r[2]);
   endfunction

   // Registers still at reset: all anchors coincide, so nothing can be solved.
   task automatic test_reset_anchors();
      send_ranges(make_item(0, 0, 0, 0));
      send_ranges(make_item(255, 65535, 65535, 65535));
      send_ranges(make_item(170, 12345, 54321, 85));
      wait_idle();
   endtask

   // A right-angle anchor layout with range extremes on every field and both tag extremes.
   task automatic test_field_extremes();
      set_anchors(0, 0, 1000, 0, 0, 1000);
      send_ranges(make_item(0, 0, 0, 0));
      send_ranges(make_item(255, 65535, 65535, 65535));
      send_ranges(make_item(1, 65535, 0, 0));
      send_ranges(make_item(2, 0, 65535, 0));
      send_ranges(make_item(3, 0, 0, 65535));
      send_ranges(make_item(85, 500, 707, 707));
      send_ranges(make_item(170, 43690, 21845, 21845));
      wait_idle();
   endtask

   // Anchors at the corners of the coordinate range, and anchors 1 and 2 sharing a y.
   task automatic test_coordinate_extremes();
      set_anchors(-32768, -32768, 32767, -32768, -32768, 32767);
      send_ranges(make_item(10, 0, 65535, 65535));
      send_ranges(make_item(11, 65535, 0, 0));
      send_ranges(make_item(12, 46341, 46341, 46341));
      wait_idle();
      set_anchors(32767, 32767, -32768, 32767, 32767, -32768);
      send_ranges(make_item(13, 0, 65535, 65535));
      send_ranges(make_item(14, 65535, 65535, 0));
      wait_idle();
   endtask

   // A determinant of one with long anchor baselines gives numerators near 2^48, so the
   // quotients run far beyond 32 bits in both directions.
   task automatic test_saturation();
      set_anchors(-32768, -32768, -32767, -32767, 32766, 32767);
      send_ranges(make_item(20, 65535, 0, 0));
      send_ranges(make_item(21, 0, 65535, 65535));
      send_ranges(make_item(22, 46341, 0, 46341));
      send_ranges(make_item(23, 3, 2, 3));
      wait_idle();
   endtask

   // Collinear anchors clear solved; writes to unused indexes must change nothing.
   task automatic test_collinear();
      set_anchors(0, 0, 100, 100, 200, 200);
      write_reg(CSR_INDEX_W'(6), 12345);
      write_reg(CSR_INDEX_W'(7), -1);
      csr_valid <= 1'b0;
      @(posedge clock);
      send_ranges(make_item(30, 100, 200, 300));
      send_ranges(make_item(31, 65535, 1, 65535));
      wait_idle();
   endtask

   // Random anchors and mostly consistent ranges, with some fully random items.
   task automatic test_random_phase(input int count, input int idle, input int stall,
                                    input int spread);
      req_type item;
      idle_pct  = idle;
      stall_pct = stall;
      set_anchors($urandom_range(2 * spread) - spread, $urandom_range(2 * spread) - spread,
                  $urandom_range(2 * spread) - spread, $urandom_range(2 * spread) - spread,
                  $urandom_range(2 * spread) - spread, $urandom_range(2 * spread) - spread);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(9) < 8)
            item = ranged_item($urandom_range(2 * spread) - spread,
                               $urandom_range(2 * spread) - spread);
         else
            item = make_item($urandom_range(255), $urandom_range(65535),
                             $urandom_range(65535), $urandom_range(65535));
         send_ranges(item);
         // Once per phase, hold off until every pending position has arrived.
         if (i == count / 2) begin
            req_valid <= 1'b0;
            while (pending_positions.size() != 0) @(posedge clock);
         end
      end
      wait_idle();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < 6; i++) anchor_pos[i] = '0;
      @(posedge clock);
      test_reset_anchors();
      test_field_extremes();
      test_coordinate_extremes();
      test_saturation();
      test_collinear();
      test_random_phase(60, 0, 0, 5000);
      test_random_phase(60, 0, 0, 32767);
      test_random_phase(60, 69, 0, 5000);
      test_random_phase(50, 69, 0, 20000);
      test_random_phase(60, 0, 69, 5000);
      test_random_phase(50, 0, 69, 32767);
      test_random_phase(60, 25, 25, 3000);
      test_random_phase(50, 25, 25, 32767);
      $display("Covered %0d requests and %0d checked responses, %0d of them unsolved,",
               sent, checked, unsolved);
      $display("over reset, extreme, saturating, collinear and random anchor layouts.");
      if (errors == 0)
         $display("trilateration_2d_three_anchor_test: PASS");
      else
         $display("trilateration_2d_three_anchor_test: FAIL");
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #2000000;
      $display("trilateration_2d_three_anchor_test: FAIL");
      $finish;
   end

endmodule
